// ===== design/pls_pkg.sv =====
// Shared types and constants for the positional list store.
package pls_pkg;

  localparam int OP_W        = 3;
  localparam int VAL_W       = 32;
  localparam int POS_W       = 8;
  localparam int ST_W        = 2;
  localparam int OUT_CNT_W   = 5;
  // Command fields are sized for the largest supported capacity (64)
  localparam int CMD_IDX_W   = 6;
  localparam int CMD_CNT_W   = 7;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP_FWD  = 3'd6,
    OP_DUMP_REV  = 3'd7
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CMD_INS      = 3'd0,
    CMD_DEL      = 3'd1,
    CMD_REPORT   = 3'd2,
    CMD_DUMP_FWD = 3'd3,
    CMD_DUMP_REV = 3'd4
  } cmd_kind_e;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] value_in;
    logic [POS_W-1:0]        position;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] value_out;
    logic [OUT_CNT_W-1:0]    item_count;
    logic                    last;
  } rsp_t;

  // Classified command passed from the front end to the back end
  typedef struct packed {
    cmd_kind_e               kind;
    status_e                 status;
    logic signed [VAL_W-1:0] value;
    logic [CMD_IDX_W-1:0]    idx;
    logic [CMD_CNT_W-1:0]    count;
  } cmd_t;

endpackage

// ===== design/pls_front.sv =====
// Front end: accepts requests, checks them against a shadow count, issues commands.
module pls_front #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  pls_pkg::req_t  req,
  input  logic           q_full,
  output logic           push,
  output pls_pkg::cmd_t  cmd
);
  import pls_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]    cnt;
  logic [CW-1:0]    cnt_next;
  logic [POS_W:0]   pos_x;
  logic [POS_W:0]   cnt_x;
  logic [POS_W:0]   cnt_p1;
  op_e              op;

  assign req_ready = !q_full;
  assign push      = req_valid && req_ready;
  assign op        = op_e'(req.operation);

  // Classify the request; count tracks every command already queued
  always_comb begin
    pos_x      = {1'b0, req.position};
    cnt_x      = (POS_W + 1)'(cnt);
    cnt_p1     = cnt_x + (POS_W + 1)'(1);
    cnt_next   = cnt;
    cmd.kind   = CMD_REPORT;
    cmd.status = ST_OK;
    cmd.value  = req.value_in;
    cmd.idx    = '0;
    case (op)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        if (op == OP_INS_AT && (pos_x == '0 || pos_x > cnt_p1)) begin
          cmd.status = ST_RANGE;
        end else if (cnt == CW'(CAPACITY)) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.kind = CMD_INS;
          cnt_next = cnt + CW'(1);
          if (op == OP_INS_BACK) begin
            cmd.idx = CMD_IDX_W'(cnt);
          end else if (op == OP_INS_AT) begin
            cmd.idx = CMD_IDX_W'(pos_x - (POS_W + 1)'(1));
          end
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
        if (cnt == '0) begin
          cmd.status = ST_EMPTY;
        end else if (op == OP_DEL_AT && (pos_x == '0 || pos_x > cnt_x)) begin
          cmd.status = ST_RANGE;
        end else begin
          cmd.kind = CMD_DEL;
          cnt_next = cnt - CW'(1);
          if (op == OP_DEL_BACK) begin
            cmd.idx = CMD_IDX_W'(cnt - CW'(1));
          end else if (op == OP_DEL_AT) begin
            cmd.idx = CMD_IDX_W'(pos_x - (POS_W + 1)'(1));
          end
        end
      end
      OP_DUMP_FWD, OP_DUMP_REV: begin
        if (cnt == '0) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.kind = (op == OP_DUMP_FWD) ? CMD_DUMP_FWD : CMD_DUMP_REV;
        end
      end
      default: begin
        cmd.status = ST_OK;
      end
    endcase
    cmd.count = CMD_CNT_W'(cnt_next);
  end

  // Shadow element count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (push) begin
      cnt <= cnt_next;
    end
  end

endmodule

// ===== design/pls_queue.sv =====
// Short command queue between the front and back ends.
module pls_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pls_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output pls_pkg::cmd_t  pop_cmd,
  output logic           empty
);
  import pls_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;

  assign full    = (fill == FW'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign pop_cmd = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + FW'(1);
      end else if (pop && !push) begin
        fill <= fill - FW'(1);
      end
    end
  end

endmodule

// ===== design/pls_back.sv =====
// Back end: shifting element array, dump sequencer and output register.
module pls_back #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  pls_pkg::cmd_t  cmd,
  output logic           pop,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output pls_pkg::rsp_t  rsp
);
  import pls_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t                  state;
  logic signed [VAL_W-1:0] elems [CAPACITY];
  logic [IW-1:0]           rd_idx;
  logic [CW-1:0]           left;
  logic [CW-1:0]           dump_cnt;
  logic                    dump_fwd;
  logic                    slot_free;
  logic                    rsp_load;
  logic                    do_ins;
  logic                    do_del;
  logic                    is_dump;
  logic [IW-1:0]           idx;

  assign slot_free = !rsp_valid || rsp_ready;
  assign pop       = (state == S_IDLE) && !q_empty && slot_free;
  assign is_dump   = (cmd.kind == CMD_DUMP_FWD) || (cmd.kind == CMD_DUMP_REV);
  assign do_ins    = pop && (cmd.kind == CMD_INS);
  assign do_del    = pop && (cmd.kind == CMD_DEL);
  assign idx       = cmd.idx[IW-1:0];
  // A new result enters the output register this cycle
  assign rsp_load  = (pop && !is_dump) || (state == S_DUMP && slot_free);

  // Element array: insert shifts up from idx, delete shifts down onto idx
  for (genvar g = 0; g < CAPACITY; g++) begin : g_elem
    localparam int PREV = (g == 0) ? 0 : g - 1;
    localparam int NEXT = (g == CAPACITY - 1) ? g : g + 1;
    localparam logic [IW-1:0] GI = IW'(g);
    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (GI == idx) begin
          elems[g] <= cmd.value;
        end else if (GI > idx) begin
          elems[g] <= elems[PREV];
        end
      end else if (do_del && GI >= idx) begin
        elems[g] <= elems[NEXT];
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop && is_dump) begin
            state <= S_DUMP;
          end
        end
        S_DUMP: begin
          if (slot_free && left == CW'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Result payload and dump cursor
  always_ff @(posedge clk) begin
    if (pop) begin
      if (is_dump) begin
        dump_fwd <= (cmd.kind == CMD_DUMP_FWD);
        dump_cnt <= cmd.count[CW-1:0];
        left     <= cmd.count[CW-1:0];
        rd_idx   <= (cmd.kind == CMD_DUMP_FWD) ? '0 : IW'(cmd.count - CMD_CNT_W'(1));
      end else begin
        rsp.status     <= cmd.status;
        rsp.value_out  <= '0;
        rsp.item_count <= OUT_CNT_W'(cmd.count);
        rsp.last       <= 1'b1;
      end
    end else if (state == S_DUMP && slot_free) begin
      rsp.status     <= ST_OK;
      rsp.value_out  <= elems[rd_idx];
      rsp.item_count <= OUT_CNT_W'(dump_cnt);
      rsp.last       <= (left == CW'(1));
      left           <= left - CW'(1);
      rd_idx         <= dump_fwd ? rd_idx + IW'(1) : rd_idx - IW'(1);
    end
  end

`ifndef SYNTHESIS
  a_dump_left: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |-> left != '0)
    else $error("dump running with nothing left to send");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop && is_dump |-> cmd.count != '0)
    else $error("dump command issued for an empty list");

  a_nonlast_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.status == ST_OK)
    else $error("non-final result carries an error status");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.value_out == '0 && rsp.last)
    else $error("error result with value or without last");
`endif

endmodule

// ===== design/positional_list_store.sv =====
// Top level of the positional list store: front end, command queue, back end.
//
//   channel   signals                        direction   carries
//   request   req_valid / req_ready / req    in          operation, value_in, position
//   response  rsp_valid / rsp_ready / rsp    out         status, value_out, item_count, last
//
// Insert, delete and error requests: one request per cycle sustained unless a dump runs or
// the sink stalls; the result passes through the command queue, then the output register.
// Dumps: the sequencer starts, then one result per element held, paced by the output register.
// The two-entry queue lets requests keep arriving while the back end dumps or the sink stalls.
// Reset (rst, synchronous) empties the list and the queue; element storage is not cleared.
module positional_list_store #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  pls_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output pls_pkg::rsp_t  rsp
);
  import pls_pkg::*;

  logic push;
  logic q_full;
  logic q_empty;
  logic pop;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  // Request classification
  pls_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  // Command queue
  pls_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // Storage and result generation
  pls_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .cmd       (pop_cmd),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
